/* hw/rtl/tsd_pkg.sv */
// shared types, codes and crc helper for the temperature scratchpad decoder
`default_nettype none
package tsd_pkg;

  typedef logic signed [18:0] temp_t;
  typedef logic [1:0]         status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_CRC_ERR = 2'd1;
  localparam status_t ST_NO_DEV  = 2'd2;

  localparam logic [3:0] IDX_TEMP_LSB     = 4'd0;
  localparam logic [3:0] IDX_TEMP_MSB     = 4'd1;
  localparam logic [3:0] IDX_COUNT_REMAIN = 4'd6;
  localparam logic [3:0] IDX_CRC          = 4'd8;

  localparam logic [7:0]  CRC_POLY     = 8'h8C;
  localparam logic [7:0]  HI_KEEP_MASK = 8'hF8;
  localparam logic [17:0] EXT_BIAS     = 18'd16;
  localparam logic [19:0] OFFSET_CENTI = 20'd25;

  localparam logic [2:0] REG_SENSOR_TYPE = 3'd0;

  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/tsd_temp_decode.sv */
// scratchpad bytes to temperature in hundredths of a degree
`default_nettype none
module tsd_temp_decode (
  input  wire logic        sensor_type,
  input  wire logic [7:0]  temp_low,
  input  wire logic [7:0]  temp_high,
  input  wire logic [7:0]  count_remain,
  output tsd_pkg::temp_t   temperature
);
  import tsd_pkg::*;

  logic [7:0]         ext_hi;
  logic [7:0]         ext_lo;
  logic signed [17:0] raw;
  logic [16:0]        mag;
  logic [18:0]        scaled;
  logic signed [19:0] signed_t;
  logic signed [19:0] adj;

  always_comb begin
    ext_hi = (temp_high & HI_KEEP_MASK) | {5'd0, temp_low[7:5]};
    ext_lo = {temp_low[4:1], 4'd0};
    if (sensor_type) begin
      raw = $signed({{2{ext_hi[7]}}, ext_hi, ext_lo}) + $signed(EXT_BIAS)
            - $signed({10'd0, count_remain});
    end else begin
      raw = $signed({{2{temp_high[7]}}, temp_high, temp_low});
    end
    mag      = raw[17] ? 17'(-raw) : raw[16:0];
    // times 6.25: 4x + 2x + x/4
    scaled   = {mag, 2'b00} + {1'b0, mag, 1'b0} + {4'd0, mag[16:2]};
    signed_t = raw[17] ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
    adj      = sensor_type ? signed_t - $signed(OFFSET_CENTI) : signed_t;
  end

  assign temperature = adj[18:0];

endmodule
`default_nettype wire

/* hw/rtl/temp_scratchpad_crc_decoder_core.sv */
// top level: scratchpad word intake, crc check, result register, config port
`default_nettype none
// Accepts one scratchpad word per clock, each with its byte index. A CRC-8 (reflected,
// polynomial 0x8C) restarts at index 0, folds in present words; bytes 0, 1 and 6 are kept.
// Index 8 yields one result in the cycle after acceptance: CRC error status, or the temperature
// in hundredths of a degree. A device-absent word also yields a no-device result in the cycle
// after acceptance and leaves the kept state alone. Throughput is one word per cycle, set by
// the single output register; the input stalls only while that register holds a result not
// yet taken. sensor_type at address 0 selects the plain 12-bit (0) or the count-remain
// extended (1) conversion; the user must write it only while the block is idle (unenforced).
module temp_scratchpad_crc_decoder_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic [3:0]        in_byte_index,
  input  wire logic              in_device_absent,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tsd_pkg::temp_t         out_temperature,
  output tsd_pkg::status_t       out_status,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import tsd_pkg::*;

  logic       sensor_type_r;
  logic [7:0] crc_r;
  logic [7:0] temp_low_r;
  logic [7:0] temp_high_r;
  logic [7:0] count_remain_r;
  logic       out_valid_r;
  temp_t      out_temp_r;
  status_t    out_status_r;

  logic       accept;
  logic       emit;
  logic [7:0] crc_nxt;
  temp_t      dec_temp;
  temp_t      out_temp_nxt;
  status_t    out_status_nxt;
  logic       cfg_wr;

  tsd_temp_decode u_decode (
    .sensor_type  (sensor_type_r),
    .temp_low     (temp_low_r),
    .temp_high    (temp_high_r),
    .count_remain (count_remain_r),
    .temperature  (dec_temp)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign emit     = in_device_absent || (in_byte_index == IDX_CRC);

  assign crc_nxt = crc8_fold((in_byte_index == IDX_TEMP_LSB) ? 8'h00 : crc_r, in_data_byte);

  always_comb begin
    if (in_device_absent) begin
      out_temp_nxt   = '0;
      out_status_nxt = ST_NO_DEV;
    end else if (crc_nxt != 8'h00) begin
      out_temp_nxt   = '0;
      out_status_nxt = ST_CRC_ERR;
    end else begin
      out_temp_nxt   = dec_temp;
      out_status_nxt = ST_OK;
    end
  end

  // scratchpad state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r          <= '0;
      temp_low_r     <= '0;
      temp_high_r    <= '0;
      count_remain_r <= '0;
    end else if (accept && !in_device_absent) begin
      crc_r <= crc_nxt;
      case (in_byte_index)
        IDX_TEMP_LSB:     temp_low_r     <= in_data_byte;
        IDX_TEMP_MSB:     temp_high_r    <= in_data_byte;
        IDX_COUNT_REMAIN: count_remain_r <= in_data_byte;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_temp_r   <= out_temp_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = out_temp_r;
  assign out_status      = out_status_r;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_type_r <= 1'b0;
    end else if (cfg_wr && (paddr == REG_SENSOR_TYPE)) begin
      sensor_type_r <= pwdata[0];
    end
  end

  assign prdata = (paddr == REG_SENSOR_TYPE) ? {31'd0, sensor_type_r} : 32'd0;

  a_err_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_temp_r == '0))
    else $error("nonzero temperature with error status");

  a_absent_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_device_absent) |=> (out_valid_r && out_status_r == ST_NO_DEV))
    else $error("device-absent word gave no no-device result");

  a_silent_word: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_device_absent && in_byte_index != IDX_CRC) |=> !out_valid_r)
    else $error("result from a word that produces none");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
`default_nettype wire

/* bench/temp_scratchpad_crc_decoder_core_test.sv */
// testbench for the temperature scratchpad decoder: scratchpad words in, checked results out
`default_nettype none
module temp_scratchpad_crc_decoder_core_test;
  import tsd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;

  class temp_scoreboard;
    bit sensor_type;
    logic [7:0] crc;
    logic [7:0] t_lo;
    logic [7:0] t_hi;
    logic [7:0] cnt_rem;
    temp_t expected_temp[$];
    status_t expected_status[$];
    int errors;
    int words;
    int ok_seen;
    int crc_err_seen;
    int no_dev_seen;

    function new();
      sensor_type = 0;
      crc = '0;
      t_lo = '0;
      t_hi = '0;
      cnt_rem = '0;
    endfunction

    static function logic [7:0] fold_crc(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] c;
      c = acc ^ b;
      for (int k = 0; k < 8; k++) begin
        if (c[0]) c = (c >> 1) ^ 8'h8C;
        else c = c >> 1;
      end
      return c;
    endfunction

    function temp_t centi_degrees();
      logic signed [15:0] w;
      int raw;
      int mag;
      int scaled;
      int t;
      if (sensor_type) begin
        w = {t_hi[7:3], t_lo[7:5], t_lo[4:1], 4'b0000};
        raw = w;
        raw = raw + 16 - int'(cnt_rem);
      end else begin
        w = {t_hi, t_lo};
        raw = w;
      end
      mag = (raw < 0) ? -raw : raw;
      scaled = mag * 6 + (mag >> 2);
      t = (raw < 0) ? -scaled : scaled;
      if (sensor_type) t = t - 25;
      return temp_t'(t);
    endfunction

    function int pending();
      return expected_temp.size();
    endfunction

    function void note_word(input logic [7:0] d, input logic [3:0] idx, input logic absent);
      words++;
      if (absent) begin
        expected_temp.push_back('0);
        expected_status.push_back(ST_NO_DEV);
        return;
      end
      if (idx == IDX_TEMP_LSB) crc = '0;
      crc = fold_crc(crc, d);
      if (idx == IDX_TEMP_LSB) t_lo = d;
      else if (idx == IDX_TEMP_MSB) t_hi = d;
      else if (idx == IDX_COUNT_REMAIN) cnt_rem = d;
      if (idx != IDX_CRC) return;
      if (crc != 0) begin
        expected_temp.push_back('0);
        expected_status.push_back(ST_CRC_ERR);
      end else begin
        expected_temp.push_back(centi_degrees());
        expected_status.push_back(ST_OK);
      end
    endfunction

    function void check_result(input temp_t temp, input status_t status);
      temp_t want_temp;
      status_t want_status;
      if (expected_temp.size() == 0) begin
        $error("result with nothing pending: temperature %0d status %0d", temp, status);
        errors++;
        return;
      end
      want_temp = expected_temp.pop_front();
      want_status = expected_status.pop_front();
      if (status !== want_status) begin
        $error("status mismatch: expected %0d actual %0d", want_status, status);
        errors++;
      end
      if (temp !== want_temp) begin
        $error("temperature mismatch: expected %0d actual %0d", want_temp, temp);
        errors++;
      end
      case (want_status)
        ST_OK: ok_seen++;
        ST_CRC_ERR: crc_err_seen++;
        default: no_dev_seen++;
      endcase
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_data_byte;
  logic [3:0] in_byte_index;
  logic in_device_absent;
  logic out_valid;
  logic out_ready;
  temp_t out_temperature;
  status_t out_status;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  temp_scoreboard sb = new();
  bit tx_quiet;
  bit rx_quiet;
  int words_sent;
  int cycles;

  temp_scratchpad_crc_decoder_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_byte_index(in_byte_index),
    .in_device_absent(in_device_absent),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_temperature(out_temperature),
    .out_status(out_status),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("temp_scratchpad_crc_decoder_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_data_byte, in_byte_index, in_device_absent);
      if (out_valid && out_ready) sb.check_result(out_temperature, out_status);
    end
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, none while rx_quiet
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap(1'b0);
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [7:0] d, input logic [3:0] idx, input logic absent);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_byte_index <= idx;
    in_device_absent <= absent;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_sensor_type(input bit v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_SENSOR_TYPE);
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.sensor_type = v;
  endtask

  // cut: number of words sent (9 for a full scratchpad); messy: stray device-absent words
  task automatic send_scratchpad(input logic [7:0] lo, input logic [7:0] hi,
                                 input logic [7:0] cr, input bit spoil,
                                 input int cut, input bit messy);
    logic [7:0] pad[9];
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < 9; i++) pad[i] = 8'($urandom);
    pad[IDX_TEMP_LSB] = lo;
    pad[IDX_TEMP_MSB] = hi;
    pad[IDX_COUNT_REMAIN] = cr;
    for (int i = 0; i < 8; i++) c = temp_scoreboard::fold_crc(c, pad[i]);
    pad[IDX_CRC] = spoil ? c ^ 8'($urandom_range(1, 255)) : c;
    for (int i = 0; i < cut; i++) begin
      if (messy && $urandom_range(0, 99) < 4)
        send_word(8'($urandom), 4'($urandom), 1'b1);
      send_word(pad[i], 4'(i), 1'b0);
    end
  endtask

  task automatic pick_reading(output logic [7:0] lo, output logic [7:0] hi,
                              output logic [7:0] cr);
    int r;
    logic [15:0] raw;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      raw = 16'($urandom);
    end else if (r < 80) begin
      raw = 16'($urandom_range(0, 2880) - 880);
    end else begin
      case ($urandom_range(0, 4))
        0: raw = 16'h7FFF;
        1: raw = 16'h8000;
        2: raw = 16'hFFFF;
        3: raw = 16'h0000;
        default: raw = 16'h0001;
      endcase
    end
    lo = raw[7:0];
    hi = raw[15:8];
    r = $urandom_range(0, 9);
    if (r < 6) cr = 8'($urandom_range(0, 16));
    else if (r < 8) cr = 8'($urandom);
    else cr = (r == 8) ? 8'h00 : 8'hFF;
  endtask

  task automatic random_words(input int n);
    int start;
    int r;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] cr;
    start = words_sent;
    while (words_sent - start < n) begin
      r = $urandom_range(0, 99);
      pick_reading(lo, hi, cr);
      if (r < 70) begin
        send_scratchpad(lo, hi, cr, 1'b0, 9, 1'b1);
      end else if (r < 78) begin
        send_scratchpad(lo, hi, cr, 1'b1, 9, 1'b1);
      end else if (r < 86) begin
        send_scratchpad(lo, hi, cr, 1'b0, $urandom_range(1, 8), 1'b0);
      end else if (r < 91) begin
        send_word(8'($urandom), 4'($urandom), 1'b1);
      end else if (r < 99) begin
        repeat ($urandom_range(1, 4)) send_word(8'($urandom), 4'($urandom), 1'b0);
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_byte_index <= '0;
    in_device_absent <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain sensor: zero, largest positive, most negative, -1, truncation toward zero
    send_scratchpad(8'h00, 8'h00, 8'h00, 1'b0, 9, 1'b0);
    send_scratchpad(8'hFF, 8'h07, 8'h00, 1'b0, 9, 1'b0);
    send_scratchpad(8'hFF, 8'h7F, 8'hFF, 1'b0, 9, 1'b0);
    send_scratchpad(8'h00, 8'h80, 8'h00, 1'b0, 9, 1'b0);
    send_scratchpad(8'hFF, 8'hFF, 8'h10, 1'b0, 9, 1'b0);
    send_scratchpad(8'h5E, 8'hFF, 8'h10, 1'b0, 9, 1'b0);
    send_scratchpad(8'h50, 8'h05, 8'h0C, 1'b1, 9, 1'b0);
    send_word(8'hA5, IDX_CRC, 1'b1);
    for (int i = 9; i < 16; i++) send_word(8'($urandom), 4'(i), 1'b0);
    send_scratchpad(8'h91, 8'h01, 8'h00, 1'b0, 4, 1'b0);
    send_scratchpad(8'h91, 8'h01, 8'h07, 1'b0, 9, 1'b0);

    // half-degree sensor: count-remain at 0, 16 and 255, both ends of the range
    write_sensor_type(1'b1);
    send_scratchpad(8'hAA, 8'h00, 8'h0C, 1'b0, 9, 1'b0);
    send_scratchpad(8'hFF, 8'hFF, 8'h00, 1'b0, 9, 1'b0);
    send_scratchpad(8'hFF, 8'hFF, 8'hFF, 1'b0, 9, 1'b0);
    send_scratchpad(8'h01, 8'h00, 8'h10, 1'b0, 9, 1'b0);
    send_scratchpad(8'h00, 8'h80, 8'hFF, 1'b0, 9, 1'b0);
    send_scratchpad(8'hFF, 8'h7F, 8'h00, 1'b0, 9, 1'b0);
    send_word(8'h00, IDX_TEMP_LSB, 1'b1);

    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    random_words(300);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    random_words(300);
    write_sensor_type(1'b0);
    random_words(500);
    write_sensor_type(1'b1);
    random_words(500);
    write_sensor_type(1'b0);
    tx_quiet = 1'b1;
    random_words(200);
    tx_quiet = 1'b0;
    random_words(200);

    drain_results();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    $display("covered %0d words over both sensor types", sb.words);
    $display("results: %0d ok, %0d crc error, %0d no device",
             sb.ok_seen, sb.crc_err_seen, sb.no_dev_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("temp_scratchpad_crc_decoder_core test passed");
    end else begin
      $display("temp_scratchpad_crc_decoder_core test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
